>>> src/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, the queue entry type and fixed widths shared by the
// front end, the command queue and the phase sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BYTE_W        = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int REQ_W         = 3;
    localparam int TICKS_W       = 16;
    localparam int PH_W          = 2;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 16'd100;

    // Bus commands. Code 7 is unused and is dropped by the front end.
    typedef enum logic [REQ_W-1:0] {
        CMD_START  = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_ACK    = 3'd2,
        CMD_NACK   = 3'd3,
        CMD_RDACK  = 3'd4,
        CMD_SEND   = 3'd5,
        CMD_READ   = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] tx;
        logic [BYTE_W-1:0] smp;
    } q_entry_t;

endpackage

>>> src/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer front end
// Accepts command words, decodes the command code, drops unused codes and
// hands valid commands to the command queue through one register stage.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic [BYTE_W-1:0] sda_sample,
    output logic              push,
    output q_entry_t          push_data,
    input  logic              q_full
);

    logic     stage_valid_reg;
    logic     stage_valid_next;
    q_entry_t stage_reg;
    q_entry_t stage_next;
    logic     code_ok;
    logic     take;

    always_comb
    begin
        case (cmd_t'(req_type))
            CMD_START, CMD_STOP, CMD_ACK, CMD_NACK,
            CMD_RDACK, CMD_SEND, CMD_READ: code_ok = 1'b1;
            default:                       code_ok = 1'b0;
        endcase
    end

    assign push     = stage_valid_reg && !q_full;
    assign in_ready = !stage_valid_reg || push;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        // An unused command code is taken and then forgotten.
        if (take && code_ok)
        begin
            stage_valid_next = 1'b1;
            stage_next.cmd   = cmd_t'(req_type);
            stage_next.tx    = tx_byte;
            stage_next.smp   = sda_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign push_data = stage_reg;

endmodule

>>> src/i2cms_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer command queue
// Short first-in first-out queue of decoded commands between the front end
// and the phase sequencer.
// ----------------------------------------------------------------------------
module i2cms_fifo
    import i2cms_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue overfilled");

endmodule

>>> src/i2cms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer phase engine
// Steps through the pin phases of the command at the head of the queue,
// keeps the present SCL and SDA levels and spaces phases by the hold timer.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [TICKS_W-1:0] cfg_wr_data,
    input  logic               q_empty,
    input  q_entry_t           head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               scl_level,
    output logic               sda_level,
    output logic               last_phase,
    output logic [BYTE_W-1:0]  rx_byte
);

    logic [TICKS_W-1:0]   phase_ticks_reg;
    logic [TICKS_W-1:0]   hold_cnt_reg;
    logic [TICKS_W-1:0]   hold_cnt_next;
    logic [PH_W-1:0]      ph_reg;
    logic [PH_W-1:0]      ph_next;
    logic [BIT_IDX_W-1:0] bit_cnt_reg;
    logic [BIT_IDX_W-1:0] bit_cnt_next;
    logic                 scl_now_reg;
    logic                 scl_now_next;
    logic                 sda_now_reg;
    logic                 sda_now_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 scl_level_reg;
    logic                 sda_level_reg;
    logic                 last_phase_reg;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic [BYTE_W-1:0]    rx_next;
    logic                 bit_end;
    logic                 byte_cmd;
    logic                 cmd_last;
    logic                 load;

    assign byte_cmd = (head.cmd == CMD_SEND) || (head.cmd == CMD_READ);
    assign load     = !q_empty && (hold_cnt_reg == '0) && (!out_valid_reg || out_ready);

    // Level changes for the current phase of the head command.
    always_comb
    begin
        scl_now_next = scl_now_reg;
        sda_now_next = sda_now_reg;
        bit_end      = 1'b0;
        case (head.cmd)
            CMD_START, CMD_STOP:
            begin
                case (ph_reg)
                    2'd0:    scl_now_next = 1'b0;
                    2'd1:    sda_now_next = (head.cmd == CMD_START);
                    2'd2:    scl_now_next = 1'b1;
                    default: sda_now_next = (head.cmd == CMD_STOP);
                endcase
                bit_end = (ph_reg == 2'd3);
            end
            CMD_ACK, CMD_NACK, CMD_SEND:
            begin
                case (ph_reg)
                    2'd0:    scl_now_next = 1'b0;
                    2'd1:
                    begin
                        if (head.cmd == CMD_SEND)
                        begin
                            sda_now_next = head.tx[3'(BITS_PER_BYTE - 1) - bit_cnt_reg];
                        end
                        else
                        begin
                            sda_now_next = (head.cmd == CMD_NACK);
                        end
                    end
                    default: scl_now_next = 1'b1;
                endcase
                bit_end = (ph_reg == 2'd2);
            end
            CMD_RDACK, CMD_READ:
            begin
                // SDA is released along with the first SCL-low phase.
                case (ph_reg)
                    2'd0:
                    begin
                        scl_now_next = 1'b0;
                        sda_now_next = 1'b1;
                    end
                    default: scl_now_next = 1'b1;
                endcase
                bit_end = (ph_reg == 2'd1);
            end
            default:
            begin
                bit_end = 1'b1;
            end
        endcase
    end

    assign cmd_last = bit_end && (!byte_cmd || (bit_cnt_reg == BIT_IDX_W'(BITS_PER_BYTE - 1)));
    assign pop      = load && cmd_last;

    always_comb
    begin
        rx_next = '0;
        if (cmd_last && (head.cmd == CMD_RDACK))
        begin
            rx_next = {{(BYTE_W - 1){1'b0}}, head.smp[BYTE_W-1]};
        end
        else if (cmd_last && (head.cmd == CMD_READ))
        begin
            // After all bits the shifted-in byte equals the sample word.
            rx_next = head.smp;
        end
    end

    always_comb
    begin
        ph_next        = ph_reg;
        bit_cnt_next   = bit_cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            ph_next        = bit_end ? '0 : ph_reg + 1'b1;
            if (cmd_last)
            begin
                bit_cnt_next = '0;
            end
            else if (bit_end)
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            hold_cnt_next = (phase_ticks_reg == '0) ? '0 : phase_ticks_reg - 1'b1;
        end
        else if (hold_cnt_reg != '0)
        begin
            hold_cnt_next = hold_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            hold_cnt_reg    <= '0;
            ph_reg          <= '0;
            bit_cnt_reg     <= '0;
            scl_now_reg     <= 1'b1;
            sda_now_reg     <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_ticks_reg <= cfg_wr_data;
            end
            hold_cnt_reg  <= hold_cnt_next;
            ph_reg        <= ph_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                scl_now_reg <= scl_now_next;
                sda_now_reg <= sda_now_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scl_level_reg  <= scl_now_next;
            sda_level_reg  <= sda_now_next;
            last_phase_reg <= cmd_last;
            rx_byte_reg    <= rx_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = scl_level_reg;
    assign sda_level  = sda_level_reg;
    assign last_phase = last_phase_reg;
    assign rx_byte    = rx_byte_reg;

    // With a phase_ticks above one, two phases never start back to back.
    a_hold_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        load && (phase_ticks_reg > 16'd1) |=> !load)
        else $error("pin phases issued closer than the hold time");

    // Only the final phase of a command carries read data.
    a_rx_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_phase_reg |-> rx_byte_reg == '0)
        else $error("read data on a phase that is not the last");

    // The bit counter only moves while a byte command is being run.
    a_bit_cnt_byte: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg != '0 |-> !q_empty && byte_cmd)
        else $error("bit counter active outside a byte command");

endmodule

>>> src/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Command-driven I2C master that expands each bus command into a run of
// SCL/SDA pin phases, one output word per pin change.
// ----------------------------------------------------------------------------
// Each command word (start, stop, ack, nack, read ack, send byte, read byte)
// turns into 2 to 24 phase words; the final one has last_phase set and, for
// read ack and read byte, carries the ack bit or the read byte on rx_byte,
// which is zero in every other word. An unused command code is taken and
// produces nothing. Phases leave one at a time from the output register,
// spaced by the hold timer, which is loaded from phase_ticks; a phase_ticks
// of zero gives the same spacing as a phase_ticks of one. The front end
// takes a new command word in every cycle while the queue has room, so
// commands line up behind the one on the bus. phase_ticks is written through
// cfg_wr_en/cfg_wr_data and only changes timing, never the phase sequence;
// write it while the block is idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration: hold time of each phase in clock cycles.
    input  logic               cfg_wr_en,
    input  logic [TICKS_W-1:0] cfg_wr_data,
    // Command words.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [BYTE_W-1:0]  tx_byte,
    input  logic [BYTE_W-1:0]  sda_sample,
    // Phase words.
    output logic               out_valid,
    input  logic               out_ready,
    output logic               scl_level,
    output logic               sda_level,
    output logic               last_phase,
    output logic [BYTE_W-1:0]  rx_byte
);

    logic     push;
    q_entry_t push_data;
    logic     q_full;
    logic     q_empty;
    logic     pop;
    q_entry_t head;

    // Decode and register incoming command words.
    i2cms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .tx_byte    (tx_byte),
        .sda_sample (sda_sample),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    // Short queue so the front end keeps taking words while the bus is busy.
    i2cms_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    // Phase engine: walks the head command and owns the bus levels.
    i2cms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .last_phase  (last_phase),
        .rx_byte     (rx_byte)
    );

endmodule

>>> bench/tb_i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives bus command words into the sequencer and checks every SCL/SDA phase
// word that comes back against a cycle-free model of the pin sequence. Tests
// run at the reset hold time, at the extremes of the hold time and at a few
// small settings, under random idling on both sides and under a long output
// stall that backs the command queue up.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer
    import i2cms_pkg::*;
;

    // The command code with no meaning; the block takes it and emits nothing.
    localparam logic [REQ_W-1:0] CMD_UNUSED = 3'd7;

    localparam int MAX_PHASES     = 24;
    // Cycles without any accepted word before the run is declared hung. The
    // longest quiet stretch is one hold at the largest hold time, or the settle
    // time before a register write after it, so this leaves room several times over.
    localparam int WATCHDOG_LIMIT = 250000;
    // Extra cycles after the last phase word before a register write, on top
    // of one full hold time, so the hold timer has run out.
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_SLACK      = 64;
    // Length of the forced output stall in the backpressure test.
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 50;

    // One expected phase word.
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              last;
        logic [BYTE_W-1:0] rx;
    } phase_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [TICKS_W-1:0] cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type;
    logic [BYTE_W-1:0]  tx_byte;
    logic [BYTE_W-1:0]  sda_sample;
    logic               out_valid;
    logic               out_ready;
    logic               scl_level;
    logic               sda_level;
    logic               last_phase;
    logic [BYTE_W-1:0]  rx_byte;

    // Model state: the pin levels the master holds and its copy of the
    // hold-time register.
    logic               bus_scl;
    logic               bus_sda;
    logic [TICKS_W-1:0] hold_ticks;

    // Phase words still owed by the block, oldest first.
    phase_t pending_phases[$];
    // Scratch run of phases for the command being modeled.
    phase_t staged[0:MAX_PHASES-1];
    int     staged_n;

    int mismatches   = 0;
    int words_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;

    i2c_master_bit_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .tx_byte     (tx_byte),
        .sda_sample  (sda_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .last_phase  (last_phase),
        .rx_byte     (rx_byte)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Pin sequence model
    // ------------------------------------------------------------------------

    // Every pin change is one phase word carrying both present pin levels.
    function automatic void stage_phase();
        phase_t p;
        p.scl = bus_scl;
        p.sda = bus_sda;
        p.last = 1'b0;
        p.rx = '0;
        staged[staged_n] = p;
        staged_n++;
    endfunction

    function automatic void drive_scl(input logic level);
        bus_scl = level;
        stage_phase();
    endfunction

    function automatic void drive_sda(input logic level);
        bus_sda = level;
        stage_phase();
    endfunction

    // Expands one accepted command word into the phase words it must cause and
    // queues them. The final word of the run is marked and carries the read
    // data, which stays zero for everything except read ack and read byte.
    function automatic void predict_pin_phases(input logic [REQ_W-1:0] code,
                                               input logic [BYTE_W-1:0] tx,
                                               input logic [BYTE_W-1:0] smp);
        logic [BYTE_W-1:0] rx;
        rx = '0;
        staged_n = 0;
        case (code)
            CMD_START:
            begin
                drive_scl(1'b0);
                drive_sda(1'b1);
                drive_scl(1'b1);
                drive_sda(1'b0);
            end
            CMD_STOP:
            begin
                drive_scl(1'b0);
                drive_sda(1'b0);
                drive_scl(1'b1);
                drive_sda(1'b1);
            end
            CMD_ACK, CMD_NACK:
            begin
                drive_scl(1'b0);
                drive_sda(code == CMD_NACK);
                drive_scl(1'b1);
            end
            CMD_RDACK:
            begin
                // SDA is let go together with the first SCL-low phase.
                bus_sda = 1'b1;
                drive_scl(1'b0);
                drive_scl(1'b1);
                rx = {{(BYTE_W-1){1'b0}}, smp[BYTE_W-1]};
            end
            CMD_SEND:
            begin
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    drive_scl(1'b0);
                    drive_sda(tx[BYTE_W-1-i]);
                    drive_scl(1'b1);
                end
            end
            CMD_READ:
            begin
                bus_sda = 1'b1;
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    drive_scl(1'b0);
                    drive_scl(1'b1);
                    rx = {rx[BYTE_W-2:0], smp[BYTE_W-1-i]};
                end
            end
            default:
                ; // The unused code leaves the pins alone and emits nothing.
        endcase
        if (staged_n > 0)
        begin
            staged[staged_n-1].last = 1'b1;
            staged[staged_n-1].rx = rx;
            for (int i = 0; i < staged_n; i++)
                pending_phases.push_back(staged[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Each phase word accepted at an edge is compared field by field with the
    // oldest word still owed.
    always @(posedge clk)
    begin : phase_checker
        phase_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_phases.size() == 0)
                report_mismatch("phase word with none outstanding", {7'd0, scl_level}, '0);
            else
            begin
                want = pending_phases.pop_front();
                if (scl_level !== want.scl)
                    report_mismatch("scl_level", {7'd0, scl_level}, {7'd0, want.scl});
                if (sda_level !== want.sda)
                    report_mismatch("sda_level", {7'd0, sda_level}, {7'd0, want.sda});
                if (last_phase !== want.last)
                    report_mismatch("last_phase", {7'd0, last_phase}, {7'd0, want.last});
                if (rx_byte !== want.rx)
                    report_mismatch("rx_byte", rx_byte, want.rx);
            end
        end
    end

    // The receiver either sits out a forced stall, counting it down here, or
    // takes each cycle at random according to its idle share.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // A run that stops accepting words on both sides is hung.
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    // Offers one command word and returns at the edge that takes it. Valid is
    // left high afterwards; the next call either replaces the payload in the
    // same step or drops valid for a random gap first.
    task automatic send_word(input logic [REQ_W-1:0] code, input logic [BYTE_W-1:0] tx,
                             input logic [BYTE_W-1:0] smp);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= code;
        tx_byte <= tx;
        sda_sample <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pin_phases(code, tx, smp);
        words_sent++;
    endtask

    // Stops offering words and waits for every owed phase word.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_phases.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only happen with the block idle: all phase words are in
    // and the hold timer of the last one has had time to run out.
    task automatic write_hold_ticks(input logic [TICKS_W-1:0] ticks);
        wait_for_drain();
        repeat (int'(hold_ticks) + SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        hold_ticks = ticks;
    endtask

    // One bus transaction with random content: start, address, then a few data
    // bytes written or read with their acknowledges, then stop. A share of the
    // calls sends a single word with any code instead, and some transactions
    // are abandoned before the stop.
    task automatic run_transaction();
        int   roll;
        int   nbytes;
        logic is_read;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            send_word(REQ_W'($urandom_range(7)), rand_byte(), rand_byte());
            return;
        end
        is_read = 1'($urandom_range(1));
        nbytes = $urandom_range(1, 4);
        send_word(CMD_START, rand_byte(), rand_byte());
        send_word(CMD_SEND, {7'($urandom_range(127)), is_read}, rand_byte());
        send_word(CMD_RDACK, rand_byte(), rand_byte());
        for (int i = 0; i < nbytes; i++)
        begin
            if (is_read)
            begin
                send_word(CMD_READ, rand_byte(), rand_byte());
                send_word((i == nbytes - 1) ? CMD_NACK : CMD_ACK, rand_byte(), rand_byte());
            end
            else
            begin
                send_word(CMD_SEND, rand_byte(), rand_byte());
                send_word(CMD_RDACK, rand_byte(), rand_byte());
            end
        end
        if (roll >= 20)
            send_word(CMD_STOP, rand_byte(), rand_byte());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A short write transaction on an idle bus with the hold time left at its
    // reset value.
    task automatic test_reset_hold();
        send_word(CMD_START, 8'h00, 8'h00);
        send_word(CMD_SEND, 8'hA5, 8'h00);
        send_word(CMD_RDACK, 8'h00, 8'h00);
        send_word(CMD_STOP, 8'h00, 8'h00);
    endtask

    // Every command with extreme data at the shortest hold time. SDA release
    // is exercised by a read ack right after sending an all-zero byte and a
    // read byte right after an ack, both with SDA held low before.
    task automatic test_commands();
        write_hold_ticks(16'd1);
        send_word(CMD_START, 8'hFF, 8'hFF);
        send_word(CMD_SEND, 8'hFF, 8'h00);
        send_word(CMD_RDACK, 8'h00, 8'h80);
        send_word(CMD_SEND, 8'h00, 8'hFF);
        send_word(CMD_RDACK, 8'hFF, 8'h7F);
        send_word(CMD_READ, 8'h00, 8'hFF);
        send_word(CMD_ACK, 8'hFF, 8'hFF);
        send_word(CMD_READ, 8'hFF, 8'h00);
        send_word(CMD_ACK, 8'h00, 8'h00);
        send_word(CMD_READ, 8'h00, 8'h5A);
        send_word(CMD_NACK, 8'h00, 8'h00);
        send_word(CMD_UNUSED, 8'hFF, 8'hFF);
        send_word(CMD_STOP, 8'h00, 8'h00);
        send_word(CMD_STOP, 8'h00, 8'h00);
        send_word(CMD_START, 8'h00, 8'h00);
        send_word(CMD_START, 8'h00, 8'h00);
    endtask

    // A hold time of zero is accepted and changes nothing in the sequence.
    task automatic test_zero_hold();
        write_hold_ticks(16'd0);
        send_word(CMD_START, 8'h00, 8'h00);
        send_word(CMD_SEND, 8'h3C, 8'h00);
        send_word(CMD_RDACK, 8'h00, 8'h00);
        send_word(CMD_STOP, 8'h00, 8'h00);
    endtask

    // The longest hold time, kept to the shortest command.
    task automatic test_max_hold();
        write_hold_ticks(16'hFFFF);
        send_word(CMD_RDACK, 8'h00, 8'h80);
    endtask

    // Random transactions at one hold time and one pair of idle shares.
    task automatic test_traffic(input logic [TICKS_W-1:0] ticks, input int tx_pct,
                                input int rx_pct, input int count);
        int target;
        write_hold_ticks(ticks);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = words_sent + count;
        while (words_sent < target)
            run_transaction();
    endtask

    // The receiver stalls for a long stretch while send byte words keep coming,
    // so the queue fills and in_ready falls; the sender then waits for every
    // phase word before sending more.
    task automatic test_backpressure();
        write_hold_ticks(16'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left <= LONG_HOLD;
        for (int i = 0; i < 6; i++)
            send_word(CMD_SEND, rand_byte(), rand_byte());
        wait_for_drain();
        send_word(CMD_READ, rand_byte(), rand_byte());
        send_word(CMD_NACK, rand_byte(), rand_byte());
        send_word(CMD_STOP, rand_byte(), rand_byte());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        req_type <= CMD_START;
        tx_byte <= '0;
        sda_sample <= '0;
        out_ready <= 1'b0;
        bus_scl = 1'b1;
        bus_sda = 1'b1;
        hold_ticks = PHASE_TICKS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hold();
        test_commands();
        test_zero_hold();
        test_max_hold();
        test_traffic(16'd3, 20, 73, 55);
        test_traffic(16'd1, 73, 20, 55);
        test_backpressure();
        test_traffic(16'd7, 0, 0, 55);

        wait_for_drain();
        repeat (int'(hold_ticks) + END_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
